/* sv/b64c_pkg.sv */
// ----------------------------------------------------------------------------
// b64c_pkg
// Types, constants and alphabet functions of the base64 stream codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned RUN_MAX = 4;
    localparam int unsigned RIDX_W = $clog2(RUN_MAX);
    localparam int unsigned CNT_W = RIDX_W + 1;

    localparam logic [7:0] LINE_LIMIT_RST = 8'd76;
    localparam logic [7:0] CH_PAD = 8'h3d;
    localparam logic [7:0] CH_NL = 8'h0a;
    localparam logic [7:0] CH_NONE = 8'd128;
    localparam logic [7:0] CH_END = 8'd64;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       stream_done;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RIDX_W-1:0]       last_idx;
        logic                    done;
    } t_run;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // 6-bit value to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] six);
        logic [7:0] v;
        v = {2'b00, six};
        if (six < 6'd26) begin
            enc_char = v + 8'h41;
        end else if (six < 6'd52) begin
            enc_char = v + 8'h61 - 8'd26;
        end else if (six < 6'd62) begin
            enc_char = v + 8'h30 - 8'd52;
        end else if (six == 6'd62) begin
            enc_char = 8'h2b;
        end else begin
            enc_char = 8'h2f;
        end
    endfunction

    // character to value: 0..63, CH_END for pad, CH_NONE otherwise
    function automatic logic [7:0] dec_value(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5a) begin
            dec_value = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            dec_value = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            dec_value = c - 8'h30 + 8'd52;
        end else if (c == 8'h2b) begin
            dec_value = 8'd62;
        end else if (c == 8'h2f) begin
            dec_value = 8'd63;
        end else if (c == CH_PAD) begin
            dec_value = CH_END;
        end else begin
            dec_value = CH_NONE;
        end
    endfunction

endpackage

/* sv/b64c_front.sv */
// ----------------------------------------------------------------------------
// b64c_front
// Accepts input transactions, runs the codec state and builds result runs.
// ----------------------------------------------------------------------------
module b64c_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  b64c_pkg::t_in      i_in,
    input  b64c_pkg::t_qstat   i_qstat,
    output logic               o_push,
    output b64c_pkg::t_run     o_run
);
    import b64c_pkg::*;

    logic             r_mode, r_fin;
    logic [7:0]       r_limit;
    logic [1:0]       r_phase, n_phase;
    logic [7:0]       r_held, n_held;
    logic [7:0]       r_lc, n_lc;
    logic             n_fin;
    logic [CNT_W-1:0] cnt;
    logic [7:0]       dv;
    logic [7:0]       c;
    logic [5:0]       six0, six1;
    logic             two;
    logic             accept;
    t_run             run;

    assign o_in_ready = !i_qstat.full;
    assign accept = i_in_valid && o_in_ready;
    assign c = i_in.data_byte;
    assign dv = dec_value(c);

    always_comb begin
        n_phase = r_phase;
        n_held = r_held;
        n_lc = r_lc;
        n_fin = r_fin;
        run = '0;
        cnt = '0;
        six0 = '0;
        six1 = '0;
        two = 1'b0;
        if (!r_fin) begin
            if (r_mode) begin
                if (i_in.end_of_input) begin
                    if (r_phase == 2'd1) begin
                        run.bytes[0] = enc_char(r_held[5:0]);
                        run.bytes[1] = CH_PAD;
                        run.bytes[2] = CH_PAD;
                        cnt = CNT_W'(3);
                    end else if (r_phase == 2'd2) begin
                        run.bytes[0] = enc_char(r_held[5:0]);
                        run.bytes[1] = CH_PAD;
                        cnt = CNT_W'(2);
                    end
                    run.bytes[cnt[RIDX_W-1:0]] = CH_NL;
                    cnt = cnt + CNT_W'(1);
                    run.done = 1'b1;
                    n_fin = 1'b1;
                    n_phase = '0;
                    n_held = '0;
                end else begin
                    case (r_phase)
                        2'd0: begin
                            six0 = c[7:2];
                            n_held = {2'b00, c[1:0], 4'b0000};
                            n_phase = 2'd1;
                        end
                        2'd1: begin
                            six0 = r_held[5:0] | {2'b00, c[7:4]};
                            n_held = {2'b00, c[3:0], 2'b00};
                            n_phase = 2'd2;
                        end
                        default: begin
                            six0 = r_held[5:0] | {4'b0000, c[7:6]};
                            six1 = c[5:0];
                            two = 1'b1;
                            n_held = '0;
                            n_phase = 2'd0;
                        end
                    endcase
                    if (n_lc >= r_limit) begin
                        run.bytes[cnt[RIDX_W-1:0]] = CH_NL;
                        cnt = cnt + CNT_W'(1);
                        n_lc = '0;
                    end
                    run.bytes[cnt[RIDX_W-1:0]] = enc_char(six0);
                    cnt = cnt + CNT_W'(1);
                    n_lc = n_lc + 8'd1;
                    if (two) begin
                        if (n_lc >= r_limit) begin
                            run.bytes[cnt[RIDX_W-1:0]] = CH_NL;
                            cnt = cnt + CNT_W'(1);
                            n_lc = '0;
                        end
                        run.bytes[cnt[RIDX_W-1:0]] = enc_char(six1);
                        cnt = cnt + CNT_W'(1);
                        n_lc = n_lc + 8'd1;
                    end
                end
            end else begin
                if (i_in.end_of_input || dv == CH_END) begin
                    cnt = CNT_W'(1);
                    run.done = 1'b1;
                    n_fin = 1'b1;
                    n_held = '0;
                end else if (dv != CH_NONE) begin
                    case (r_phase)
                        2'd0: begin
                            n_held = {dv[5:0], 2'b00};
                        end
                        2'd1: begin
                            run.bytes[0] = r_held | {6'd0, dv[5:4]};
                            cnt = CNT_W'(1);
                            n_held = {dv[3:0], 4'b0000};
                        end
                        2'd2: begin
                            run.bytes[0] = r_held | {4'd0, dv[5:2]};
                            cnt = CNT_W'(1);
                            n_held = {dv[1:0], 6'd0};
                        end
                        default: begin
                            run.bytes[0] = r_held | {2'd0, dv[5:0]};
                            cnt = CNT_W'(1);
                            n_held = '0;
                        end
                    endcase
                    n_phase = r_phase + 2'd1;
                end
            end
        end
        run.last_idx = RIDX_W'(cnt - CNT_W'(1));
    end

    assign o_push = accept && (cnt != '0);
    assign o_run = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_limit <= LINE_LIMIT_RST;
            r_phase <= '0;
            r_held <= '0;
            r_lc <= '0;
            r_fin <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE: begin
                    r_mode <= i_cfg_data[0];
                    r_phase <= '0;
                    r_held <= '0;
                    r_lc <= '0;
                    r_fin <= 1'b0;
                end
                CFG_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end else if (accept) begin
            r_phase <= n_phase;
            r_held <= n_held;
            r_lc <= n_lc;
            r_fin <= n_fin;
        end
    end

endmodule

/* sv/b64c_queue.sv */
// ----------------------------------------------------------------------------
// b64c_queue
// Small FIFO of result runs between front and back.
// ----------------------------------------------------------------------------
module b64c_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64c_pkg::t_run   i_run,
    input  logic             i_pop,
    output b64c_pkg::t_run   o_run,
    output b64c_pkg::t_qstat o_stat
);
    import b64c_pkg::*;

    t_run              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              do_pop;

    assign o_stat.full = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_pop = i_pop && !o_stat.empty;
    assign o_run = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            case ({i_push, do_pop})
                2'b10: r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01: r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: ;
            endcase
        end
    end

endmodule

/* sv/b64c_back.sv */
// ----------------------------------------------------------------------------
// b64c_back
// Unpacks result runs into one output transaction per cycle while i_out_ready is high.
// ----------------------------------------------------------------------------
module b64c_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  b64c_pkg::t_run   i_run,
    input  b64c_pkg::t_qstat i_qstat,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output b64c_pkg::t_out   o_out
);
    import b64c_pkg::*;

    t_run              r_ent;
    logic [RIDX_W-1:0] r_idx;
    logic              r_busy;
    logic              r_ovalid;
    t_out              r_out;
    logic              can_load;
    logic              at_last;

    assign can_load = !r_ovalid || i_out_ready;
    assign at_last = (r_idx == r_ent.last_idx);
    assign o_pop = !i_qstat.empty && (!r_busy || (can_load && at_last));
    assign o_out_valid = r_ovalid;
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        if (can_load && r_busy) begin
            r_out.out_byte <= r_ent.bytes[r_idx];
            r_out.stream_done <= r_ent.done && at_last;
            r_out.last_of_run <= at_last;
        end
        if (o_pop) begin
            r_ent <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (can_load) begin
                r_ovalid <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx <= '0;
            end else if (can_load && r_busy) begin
                if (at_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + RIDX_W'(1);
                end
            end
        end
    end

endmodule

/* sv/base64_stream_codec.sv */
// Path: an accepted input transaction is written to the run queue, then popped into
// the back end run register and unpacked into the output register. Throughput: one
// result per cycle while runs are queued and i_out_ready is high; an input transaction
// is accepted every cycle while the 4-entry run queue has room.
// Reset: synchronous active low; decode mode, line limit 76, control state cleared.
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder/decoder with line breaking and padding.
// ----------------------------------------------------------------------------
module base64_stream_codec (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [0:0]     i_cfg_idx,
    input  logic [7:0]     i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  b64c_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output b64c_pkg::t_out o_out
);
    import b64c_pkg::*;

    logic   push, pop;
    t_run   run_in, run_out;
    t_qstat qstat;

    b64c_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_run      (run_in)
    );

    b64c_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run_in),
        .i_pop   (pop),
        .o_run   (run_out),
        .o_stat  (qstat)
    );

    b64c_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run       (run_out),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && qstat.full))
        else $error("run queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && qstat.empty))
        else $error("run queue underflow");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.stream_done |-> o_out.last_of_run)
        else $error("stream_done without last_of_run");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && qstat.empty)
        else $error("output valid after reset");
`endif

endmodule
